>>> rtl/first_fit_range_allocator_defines.svh
`ifndef FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFRA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// next-cycle implication
`define FFRA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

>>> rtl/ffra_pkg.sv
`timescale 1ns / 1ps
package ffra_pkg;
   localparam int MaxRanges = 64;
   localparam int IdxW      = $clog2(MaxRanges);
   localparam int CntW      = $clog2(MaxRanges + 1);
   localparam logic [24:0] CapLimit = 25'd16777216;
   localparam logic [24:0] CapReset = 25'd262144;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOFIT  = 2'd1,
      ST_DOUBLE = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_APPLY,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      MK_NONE,
      MK_SHRINK,
      MK_GROW,
      MK_PREPEND
   } mod_kind_type;

   typedef struct packed {
      logic [23:0] base;
      logic [24:0] length;
   } entry_type;
endpackage

>>> rtl/ffra_cell.sv
`timescale 1ns / 1ps
module ffra_cell import ffra_pkg::*; (
   input  logic        clock,
   input  logic        shift,
   input  entry_type   load,
   output entry_type   held,
   output logic [25:0] stop
);
   entry_type ent_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         ent_ff <= load;
      end
   end

   assign held = ent_ff;
   assign stop = {2'b00, ent_ff.base} + {1'b0, ent_ff.length};
endmodule

>>> rtl/first_fit_range_allocator.sv
`timescale 1ns / 1ps
// channel   | ports                                   | handshake
// request   | req_command, req_position, req_count    | start & !busy
// result    | rsp_start_res, rsp_status, rsp_free_entries | rsp_valid strobe
// csr       | csr_capacity                            | csr_valid & csr_ready
// every request runs from one acceptance to the next through these steps: one full turn of the
// cell ring to scan, a decide step, one turn to apply, a respond step and an idle step;
// failed requests skip the apply turn.
// after reset or a capacity write the ring runs one clearing turn with busy high.
// the result is a one-cycle strobe; no stall exists.
module first_fit_range_allocator import ffra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [23:0] req_position,
   input  logic [24:0] req_count,
   output logic        rsp_valid,
   output logic [23:0] rsp_start_res,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_free_entries,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [24:0] csr_capacity
);
`include "first_fit_range_allocator_defines.svh"

   state_type    state_ff, state_in;
   logic [IdxW-1:0] t_ff;
   logic [CntW-1:0] used_ff;
   logic [24:0]  cap_ff;
   logic         cmd_ff;
   logic [23:0]  pos_ff;
   logic [24:0]  cnt_ff;
   logic         found_ff, frem_ff, dbl_ff, has_lo_ff, has_hi_ff;
   logic [IdxW-1:0] fidx_ff, lo_ff, hi_ff;
   logic [23:0]  fstart_ff;
   logic [24:0]  hi_len_ff;
   mod_kind_type kind_ff;
   logic [IdxW-1:0] mod_idx_ff, rm_idx_ff;
   logic [24:0]  add_ff;
   logic         rm_en_ff, app_en_ff;
   status_type   status_ff;
   logic [23:0]  start_ff;

   entry_type    cell_out [MaxRanges];
   entry_type    cell_in  [MaxRanges];
   logic [25:0]  cell_end [MaxRanges];
   entry_type    tail;
   logic         shift;
   logic         last;
   logic         accept;

   assign shift  = (state_ff == S_CLEAR) || (state_ff == S_SCAN) || (state_ff == S_APPLY);
   assign last   = (t_ff == IdxW'(MaxRanges - 1));
   assign accept = start && !busy;

   genvar gi;
   generate
      for (gi = 0; gi < MaxRanges; gi++) begin : g_cell
         if (gi == MaxRanges - 1) begin : g_tail
            assign cell_in[gi] = tail;
         end else begin : g_link
            assign cell_in[gi] = cell_out[gi + 1];
         end
         ffra_cell u_cell (
            .clock (clock),
            .shift (shift),
            .load  (cell_in[gi]),
            .held  (cell_out[gi]),
            .stop  (cell_end[gi])
         );
      end
   endgenerate

   // ring feed
   logic            use_next;
   entry_type       src;
   logic [IdxW-1:0] sidx;
   always_comb begin
      use_next = rm_en_ff && (t_ff >= rm_idx_ff);
      src      = use_next ? cell_out[1] : cell_out[0];
      sidx     = use_next ? t_ff + IdxW'(1) : t_ff;
      tail     = cell_out[0];
      case (state_ff)
         S_CLEAR: begin
            tail = '0;
            if (t_ff == '0 && cap_ff != '0) begin
               tail.length = cap_ff;
            end
         end
         S_APPLY: begin
            tail = src;
            if (sidx == mod_idx_ff) begin
               case (kind_ff)
                  MK_SHRINK: begin
                     tail.base   = 24'({1'b0, src.base} + cnt_ff);
                     tail.length = src.length - cnt_ff;
                  end
                  MK_GROW: begin
                     tail.length = src.length + add_ff;
                  end
                  MK_PREPEND: begin
                     tail.base   = pos_ff;
                     tail.length = src.length + cnt_ff;
                  end
                  default: begin
                  end
               endcase
            end
            if (app_en_ff && ({1'b0, t_ff} == used_ff)) begin
               tail.base   = pos_ff;
               tail.length = cnt_ff;
            end
            if (use_next && last) begin
               tail = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // scan compares on the head cell
   logic        slot_ok;
   logic [25:0] pos26, end26;
   assign slot_ok = ({1'b0, t_ff} < used_ff);
   assign pos26   = {2'b00, pos_ff};
   assign end26   = pos26 + {1'b0, cnt_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (last) state_in = S_IDLE;
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
            end else if (csr_valid) begin
               state_in = S_CLEAR;
            end
         end
         S_SCAN:   if (last) state_in = S_DECIDE;
         S_DECIDE: begin
            state_in = S_DONE;
            if (cmd_ff == CMD_ALLOC) begin
               if (found_ff) state_in = S_APPLY;
            end else if (cnt_ff != '0 && !dbl_ff && end26 <= {1'b0, cap_ff}) begin
               if (has_lo_ff || has_hi_ff || used_ff < CntW'(MaxRanges)) begin
                  state_in = S_APPLY;
               end
            end
         end
         S_APPLY:  if (last) state_in = S_DONE;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff    <= '0;
         used_ff <= '0;
         cap_ff  <= CapReset;
      end else begin
         t_ff <= shift ? t_ff + IdxW'(1) : '0;
         if (state_ff == S_CLEAR && last) begin
            used_ff <= (cap_ff != '0) ? CntW'(1) : '0;
         end
         if (state_ff == S_APPLY && last) begin
            used_ff <= used_ff - CntW'(rm_en_ff) + CntW'(app_en_ff);
         end
         if (csr_valid && csr_ready) begin
            cap_ff <= (csr_capacity > CapLimit) ? CapLimit : csr_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_command;
         pos_ff    <= req_position;
         cnt_ff    <= req_count;
         found_ff  <= 1'b0;
         frem_ff   <= 1'b0;
         dbl_ff    <= 1'b0;
         has_lo_ff <= 1'b0;
         has_hi_ff <= 1'b0;
         fidx_ff   <= '0;
         lo_ff     <= '0;
         hi_ff     <= '0;
         fstart_ff <= '0;
         hi_len_ff <= '0;
      end
      if (state_ff == S_SCAN && slot_ok) begin
         if (cmd_ff == CMD_ALLOC) begin
            if (!found_ff && cell_out[0].length >= cnt_ff) begin
               found_ff  <= 1'b1;
               fidx_ff   <= t_ff;
               fstart_ff <= cell_out[0].base;
               frem_ff   <= (cell_out[0].length == cnt_ff) && (cnt_ff != '0);
            end
         end else if ({2'b00, cell_out[0].base} < pos26) begin
            if (cell_end[0] > pos26) dbl_ff <= 1'b1;
            if (cell_end[0] == pos26 && !has_lo_ff) begin
               has_lo_ff <= 1'b1;
               lo_ff     <= t_ff;
            end
         end else begin
            if (end26 > {2'b00, cell_out[0].base}) dbl_ff <= 1'b1;
            if (end26 == {2'b00, cell_out[0].base} && !has_hi_ff) begin
               has_hi_ff <= 1'b1;
               hi_ff     <= t_ff;
               hi_len_ff <= cell_out[0].length;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= MK_NONE;
         rm_en_ff  <= 1'b0;
         app_en_ff <= 1'b0;
      end else if (state_ff == S_DECIDE) begin
         kind_ff    <= MK_NONE;
         rm_en_ff   <= 1'b0;
         app_en_ff  <= 1'b0;
         mod_idx_ff <= '0;
         rm_idx_ff  <= '0;
         add_ff     <= cnt_ff;
         start_ff   <= '0;
         status_ff  <= ST_OK;
         if (cmd_ff == CMD_ALLOC) begin
            if (!found_ff) begin
               status_ff <= ST_NOFIT;
            end else begin
               start_ff <= fstart_ff;
               if (frem_ff) begin
                  rm_en_ff  <= 1'b1;
                  rm_idx_ff <= fidx_ff;
               end else begin
                  kind_ff    <= MK_SHRINK;
                  mod_idx_ff <= fidx_ff;
               end
            end
         end else if (cnt_ff == '0) begin
            status_ff <= ST_OK;
         end else if (dbl_ff || end26 > {1'b0, cap_ff}) begin
            status_ff <= ST_DOUBLE;
         end else if (has_lo_ff) begin
            kind_ff    <= MK_GROW;
            mod_idx_ff <= lo_ff;
            if (has_hi_ff) begin
               add_ff    <= cnt_ff + hi_len_ff;
               rm_en_ff  <= 1'b1;
               rm_idx_ff <= hi_ff;
            end
         end else if (has_hi_ff) begin
            kind_ff    <= MK_PREPEND;
            mod_idx_ff <= hi_ff;
         end else if (used_ff >= CntW'(MaxRanges)) begin
            status_ff <= ST_FULL;
         end else begin
            app_en_ff <= 1'b1;
         end
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = (state_ff == S_IDLE) && !start;
   assign rsp_valid        = (state_ff == S_DONE);
   assign rsp_start_res    = start_ff;
   assign rsp_status       = status_ff;
   assign rsp_free_entries = 7'(used_ff);

   `FFRA_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `FFRA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `FFRA_ASSERT_NOW(a_used_max, clock, reset, 1'b1, used_ff <= CntW'(MaxRanges))
   `FFRA_ASSERT_NOW(a_rm_app_excl, clock, reset, state_ff == S_APPLY, !(rm_en_ff && app_en_ff))
   `FFRA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_status != ST_OK,
      rsp_start_res == '0)
endmodule

>>> test/tb_first_fit_range_allocator.sv
`timescale 1ns / 1ps
module tb_first_fit_range_allocator;
   import ffra_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 2 * MaxRanges + 12;

   typedef struct {
      logic [23:0] start_res;
      status_type  status;
      logic [6:0]  entries;
   } outcome_t;

   typedef struct {
      logic        cmd;
      logic [23:0] pos;
      logic [24:0] cnt;
      bit          typed;
      status_type  st;
      logic [23:0] start_res;
   } dir_row_t;

   typedef struct {
      logic [23:0] pos;
      logic [24:0] cnt;
   } held_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = CMD_ALLOC;
   logic [23:0] req_position = '0;
   logic [24:0] req_count = '0;
   logic        rsp_valid;
   logic [23:0] rsp_start_res;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_free_entries;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [24:0] csr_capacity = '0;

   logic [24:0] cap_q;
   logic [23:0] free_begin [MaxRanges];
   logic [24:0] free_len [MaxRanges];
   int          free_used;

   outcome_t pending_q [$];
   held_t    held_q [$];
   int       n_fail = 0;
   int       n_checked = 0;
   int       n_sent = 0;
   int       n_status [4];
   int       cycles = 0;
   bit       quiet = 1'b0;

   dir_row_t dir_rows [17] = '{
      '{CMD_ALLOC, 24'd0,        25'd0,         1'b1, ST_OK,     24'd0},
      '{CMD_ALLOC, 24'd0,        25'd16,        1'b1, ST_OK,     24'd0},
      '{CMD_ALLOC, 24'd0,        25'd262144,    1'b1, ST_NOFIT,  24'd0},
      '{CMD_FREE,  24'd0,        25'd0,         1'b1, ST_OK,     24'd0},
      '{CMD_FREE,  24'd262140,   25'd10,        1'b1, ST_DOUBLE, 24'd0},
      '{CMD_FREE,  24'd0,        25'd16,        1'b1, ST_OK,     24'd0},
      '{CMD_FREE,  24'd0,        25'd1,         1'b1, ST_DOUBLE, 24'd0},
      '{CMD_ALLOC, 24'hABCDEF,   25'd262144,    1'b1, ST_OK,     24'd0},
      '{CMD_ALLOC, 24'd0,        25'd0,         1'b1, ST_NOFIT,  24'd0},
      '{CMD_ALLOC, 24'd0,        25'd1,         1'b1, ST_NOFIT,  24'd0},
      '{CMD_FREE,  24'd100,      25'd10,        1'b0, ST_OK,     24'd0},
      '{CMD_FREE,  24'd300,      25'd10,        1'b0, ST_OK,     24'd0},
      '{CMD_FREE,  24'd110,      25'd190,       1'b0, ST_OK,     24'd0},
      '{CMD_FREE,  24'hFFFFFF,   25'd1,         1'b1, ST_DOUBLE, 24'd0},
      '{CMD_FREE,  24'd0,        25'h1FFFFFF,   1'b1, ST_DOUBLE, 24'd0},
      '{CMD_ALLOC, 24'd0,        25'h1FFFFFF,   1'b1, ST_NOFIT,  24'd0},
      '{CMD_ALLOC, 24'd0,        25'd200,       1'b0, ST_OK,     24'd0}
   };

   first_fit_range_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_position(req_position), .req_count(req_count),
      .rsp_valid(rsp_valid), .rsp_start_res(rsp_start_res), .rsp_status(rsp_status),
      .rsp_free_entries(rsp_free_entries),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_capacity(csr_capacity)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // table model
   task automatic set_capacity(input logic [24:0] v);
      cap_q = (v > CapLimit) ? CapLimit : v;
      for (int i = 0; i < MaxRanges; i++) begin
         free_begin[i] = '0;
         free_len[i] = '0;
      end
      free_used = (cap_q == 0) ? 0 : 1;
      free_len[0] = cap_q;
   endtask

   task automatic drop_range(input int idx);
      for (int i = idx; i + 1 < free_used; i++) begin
         free_begin[i] = free_begin[i + 1];
         free_len[i] = free_len[i + 1];
      end
      free_begin[free_used - 1] = '0;
      free_len[free_used - 1] = '0;
      free_used--;
   endtask

   task automatic take_range(input logic [24:0] cnt, output outcome_t o);
      o.start_res = '0;
      o.status = ST_NOFIT;
      for (int i = 0; i < free_used; i++) begin
         if (free_len[i] >= cnt) begin
            o.start_res = free_begin[i];
            o.status = ST_OK;
            if (free_len[i] == cnt && cnt != 0) begin
               drop_range(i);
            end else begin
               free_begin[i] = free_begin[i] + cnt[23:0];
               free_len[i] = free_len[i] - cnt;
            end
            return;
         end
      end
   endtask

   task automatic give_back(input logic [23:0] pos, input logic [24:0] cnt,
                            output status_type st);
      logic [25:0] fin;
      logic [25:0] b;
      logic [25:0] e;
      int          lo;
      int          hi;
      lo = -1;
      hi = -1;
      fin = {2'b0, pos} + {1'b0, cnt};
      st = ST_OK;
      if (cnt == 0) return;
      if (fin > {1'b0, cap_q}) begin
         st = ST_DOUBLE;
         return;
      end
      for (int i = 0; i < free_used; i++) begin
         b = {2'b0, free_begin[i]};
         e = b + {1'b0, free_len[i]};
         if (b < {2'b0, pos}) begin
            if (e > {2'b0, pos}) begin
               st = ST_DOUBLE;
               return;
            end
            if (e == {2'b0, pos} && lo < 0) lo = i;
         end else begin
            if (fin > b) begin
               st = ST_DOUBLE;
               return;
            end
            if (fin == b && hi < 0) hi = i;
         end
      end
      if (lo >= 0 && hi >= 0) begin
         free_len[lo] = free_len[lo] + cnt + free_len[hi];
         drop_range(hi);
      end else if (lo >= 0) begin
         free_len[lo] = free_len[lo] + cnt;
      end else if (hi >= 0) begin
         free_begin[hi] = pos;
         free_len[hi] = free_len[hi] + cnt;
      end else if (free_used >= MaxRanges) begin
         st = ST_FULL;
      end else begin
         free_begin[free_used] = pos;
         free_len[free_used] = cnt;
         free_used++;
      end
   endtask

   task automatic predict_request(input logic cmd, input logic [23:0] pos,
                                  input logic [24:0] cnt, output outcome_t o);
      o.start_res = '0;
      if (cmd == CMD_ALLOC) take_range(cnt, o);
      else give_back(pos, cnt, o.status);
      o.entries = free_used[6:0];
   endtask

   // drive one request and wait for its acceptance
   task automatic send_request(input logic cmd, input logic [23:0] pos,
                               input logic [24:0] cnt, input bit typed,
                               input status_type st, input logic [23:0] s0);
      outcome_t o;
      held_t    h;
      if (!quiet && $urandom_range(99) < 15) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_position <= pos;
      req_count <= cnt;
      do @(posedge clock); while (busy);
      predict_request(cmd, pos, cnt, o);
      if (typed) begin
         o.status = st;
         o.start_res = s0;
      end
      if (cmd == CMD_ALLOC && o.status == ST_OK && cnt != 0) begin
         h.pos = o.start_res;
         h.cnt = cnt;
         held_q = {held_q, h};
      end
      n_status[o.status]++;
      pending_q = {pending_q, o};
      n_sent++;
   endtask

   task automatic write_capacity(input logic [24:0] v);
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_capacity <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      set_capacity(v);
      held_q.delete();
   endtask

   task automatic random_request();
      int          pick;
      int          k;
      held_t       h;
      logic [24:0] span;
      logic [24:0] part;
      pick = $urandom_range(99);
      span = (cap_q < 16) ? 25'd1 : cap_q / 16;
      if (pick < 50 || (pick < 85 && held_q.size() == 0)) begin
         send_request(CMD_ALLOC, 24'($urandom), 25'($urandom_range(1, span)),
                      1'b0, ST_OK, '0);
      end else if (pick < 55) begin
         send_request(CMD_ALLOC, 24'($urandom), 25'd0, 1'b0, ST_OK, '0);
      end else if (pick < 85) begin
         k = $urandom_range(held_q.size() - 1);
         h = held_q[k];
         held_q.delete(k);
         part = 25'($urandom_range(1, h.cnt));
         if ($urandom_range(1)) begin
            send_request(CMD_FREE, h.pos, part, 1'b0, ST_OK, '0);
            if (part < h.cnt) held_q = {held_q, held_t'{h.pos + part[23:0], h.cnt - part}};
         end else begin
            send_request(CMD_FREE, h.pos + 24'(h.cnt - part), part, 1'b0, ST_OK, '0);
            if (part < h.cnt) held_q = {held_q, held_t'{h.pos, h.cnt - part}};
         end
      end else if (pick < 93) begin
         send_request(CMD_FREE, 24'($urandom_range(cap_q)), 25'($urandom_range(1, span)),
                      1'b0, ST_OK, '0);
      end else begin
         send_request(1'($urandom_range(1)), 24'($urandom), 25'($urandom), 1'b0, ST_OK, '0);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      outcome_t w;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            $error("response with no request outstanding");
            n_fail++;
         end else begin
            w = pending_q.pop_front();
            n_checked++;
            if (rsp_start_res !== w.start_res) begin
               $error("start_res expected %0d got %0d", w.start_res, rsp_start_res);
               n_fail++;
            end
            if (rsp_status !== w.status) begin
               $error("status expected %0d got %0d", w.status, rsp_status);
               n_fail++;
            end
            if (rsp_free_entries !== w.entries) begin
               $error("free_entries expected %0d got %0d", w.entries, rsp_free_entries);
               n_fail++;
            end
         end
      end
   end

   initial begin
      logic [24:0] caps [7];
      int          lens [7];
      caps = '{25'd1, 25'h1FFFFFF, 25'd256, 25'd4096, 25'd100000, 25'd0, 25'd0};
      lens = '{30, 250, 260, 250, 250, 10, 80};
      caps[6] = 25'($urandom_range(1, 16777216));
      set_capacity(CapReset);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_request(dir_rows[i].cmd, dir_rows[i].pos, dir_rows[i].cnt,
                      dir_rows[i].typed, dir_rows[i].st, dir_rows[i].start_res);
      for (int p = 0; p < 7; p++) begin
         write_capacity(caps[p]);
         quiet = (p == 3);
         repeat (lens[p]) random_request();
      end
      quiet = 1'b0;
      // fragment a small buffer until the table overflows
      write_capacity(25'd140);
      send_request(CMD_ALLOC, '0, 25'd140, 1'b0, ST_OK, '0);
      for (int k = 0; k < 70; k++)
         send_request(CMD_FREE, 24'(2 * k), 25'd1, 1'b0, ST_OK, '0);
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests checked over 9 capacity settings", n_checked);
      $display("status mix ok/nofit/double/full: %0d/%0d/%0d/%0d",
               n_status[0], n_status[1], n_status[2], n_status[3]);
      if (n_fail == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
